[src/jais_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jais_pkg
// Shared codes and field widths for the jog axis and increment selector.
// ----------------------------------------------------------------------------
package jais_pkg;

  // Widths of the fields on the ports.
  localparam int ACTION_W     = 3;
  localparam int MASK_FIELD_W = 9;
  localparam int SLOT_IN_W    = 4;
  localparam int VALUE_W      = 32;
  localparam int AXIS_FIELD_W = 4;
  localparam int SLOT_FIELD_W = 3;
  localparam int INCR_FIELD_W = 20;
  localparam int LIMIT_W      = 20;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_NEXT_AXIS  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PREV_AXIS  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET_MASK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE_INCR = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE    = 3'd4;

  // Status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Reset values: 9.999 with 16 fraction bits, and axes 0, 1, 2 and 6 enabled.
  localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 20'd655294;
  localparam logic [MASK_FIELD_W-1:0] MASK_RESET  = 9'd71;

endpackage : jais_pkg
`default_nettype wire

[src/jais_slot_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jais_slot_table
// Jog increment table with per-slot nonzero flags, one write port, one data
// read port and one nonzero probe port.
// ----------------------------------------------------------------------------
module jais_slot_table #(
  parameter int NUM_SLOTS  = 6,
  parameter int INCR_WIDTH = 20,
  parameter int SLOT_W     = $clog2(NUM_SLOTS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [SLOT_W-1:0]                 wr_addr,
  input  wire logic [INCR_WIDTH-1:0]             wr_data,
  input  wire logic [SLOT_W-1:0]                 rd_addr,
  output logic      [jais_pkg::INCR_FIELD_W-1:0] rd_data,
  input  wire logic [SLOT_W-1:0]                 probe_addr,
  output logic                                   probe_nonzero
);
  import jais_pkg::*;

  localparam int EXT_W = INCR_WIDTH + INCR_FIELD_W;

  logic [INCR_WIDTH-1:0] slot_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  nonzero;
  logic [INCR_WIDTH-1:0] entry;
  logic [EXT_W-1:0]      entry_ext;

  // Entries are only trusted once flagged nonzero, so the data needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      nonzero <= '0;
    end else if (wr_en) begin
      nonzero[wr_addr] <= (wr_data != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    entry         = nonzero[rd_addr] ? slot_mem[rd_addr] : '0;
    entry_ext     = EXT_W'(entry);
    rd_data       = entry_ext[INCR_FIELD_W-1:0];
    probe_nonzero = nonzero[probe_addr];
  end

endmodule : jais_slot_table
`default_nettype wire

[src/jog_axis_increment_selector_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jog_axis_increment_selector_core
// Keeps the selected jog axis, the axis enable mask, the jog increment table
// and the selected increment slot, and reports them after every action word.
// ----------------------------------------------------------------------------
// Sequence: set mask without snap, rejects and unused codes go from S_IDLE
// to S_DONE; a valid write passes S_CHECK first; axis moves, mask snaps,
// advance and searching writes pass S_SCAN, which probes one place a cycle.
// The result strobe is registered from S_DONE. Throughput: one word at a time;
// a new word is taken in the strobe cycle, and results cannot be stalled.
// Reset: synchronous, limit 9.999, axes 0, 1, 2 and 6 enabled, table empty.
// ----------------------------------------------------------------------------
module jog_axis_increment_selector_core #(
  parameter int NUM_AXES   = 9,
  parameter int NUM_SLOTS  = 6,
  parameter int INCR_WIDTH = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Command channel.
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [jais_pkg::ACTION_W-1:0]     action,
  input  wire logic [jais_pkg::MASK_FIELD_W-1:0] axis_mask,
  input  wire logic [jais_pkg::SLOT_IN_W-1:0]    slot_index,
  input  wire logic signed [jais_pkg::VALUE_W-1:0] increment_value,
  // Result channel.
  output logic                                   done,
  output logic [jais_pkg::AXIS_FIELD_W-1:0]      selected_axis,
  output logic [jais_pkg::SLOT_FIELD_W-1:0]      selected_slot,
  output logic [jais_pkg::INCR_FIELD_W-1:0]      active_increment,
  output logic                                   status,
  // Configuration channel: the increment limit.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [jais_pkg::LIMIT_W-1:0]      cfg_data
);
  import jais_pkg::*;

  localparam int AXIS_W   = $clog2(NUM_AXES);
  localparam int SLOT_W   = $clog2(NUM_SLOTS);
  localparam int IDX_W    = (AXIS_W > SLOT_W) ? AXIS_W : SLOT_W;
  localparam int SCAN_MAX = (NUM_AXES > NUM_SLOTS) ? NUM_AXES : NUM_SLOTS;
  localparam int CNT_W    = $clog2(SCAN_MAX + 1);
  localparam int MEXT_W   = NUM_AXES + MASK_FIELD_W;
  localparam int SEXT_W   = SLOT_W + SLOT_FIELD_W;

  localparam logic [MEXT_W-1:0] MASK_RESET_EXT = MEXT_W'(MASK_RESET);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;

  // Architectural state.
  logic [LIMIT_W-1:0]  increment_limit;
  logic [AXIS_W-1:0]   axis_sel;
  logic [NUM_AXES-1:0] enable_bits;
  logic [SLOT_W-1:0]   slot_sel;

  // Sequencer registers for the cyclic search.
  logic [IDX_W-1:0]    cand;
  logic [CNT_W-1:0]    cnt;
  logic                scan_fwd;
  logic                scan_axis;
  logic                zero_fallback;
  logic                status_r;

  // Input decode.
  logic [MEXT_W-1:0]   mask_ext;
  logic [NUM_AXES-1:0] mask_m;
  logic [VALUE_W-1:0]  incr_u;
  logic                incr_bad;
  logic                wr_en;
  logic                cmd_reject;

  // Shared step and probe unit.
  logic [IDX_W-1:0]    scan_last;
  logic [IDX_W-1:0]    nxt;
  logic                axis_hit;
  logic                hit;
  logic [SLOT_W-1:0]   probe_addr;
  logic                probe_nonzero;
  logic [INCR_FIELD_W-1:0] rd_data;
  logic [SEXT_W-1:0]   slot_ext;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Only the low NUM_AXES bits of the offered mask count.
  always_comb begin
    mask_ext = MEXT_W'(axis_mask);
    mask_m   = mask_ext[NUM_AXES-1:0];
  end

  // A write is rejected for a slot past the table, a negative value, a value
  // above the limit, or a value too wide for the table entries.
  always_comb begin
    incr_u   = increment_value;
    incr_bad = ({1'b0, slot_index} >= (SLOT_IN_W + 1)'(NUM_SLOTS)) ||
               incr_u[VALUE_W-1] ||
               (incr_u > VALUE_W'(increment_limit)) ||
               ((incr_u >> INCR_WIDTH) != '0);
    wr_en    = (state == S_IDLE) && start && (action == ACT_WRITE_INCR) && !incr_bad;
  end

  // Status of the word being taken: a zero mask, a bad write or an unused
  // action code is rejected.
  always_comb begin
    case (action)
      ACT_NEXT_AXIS, ACT_PREV_AXIS, ACT_ADVANCE: cmd_reject = 1'b0;
      ACT_SET_MASK:   cmd_reject = (mask_m == '0);
      ACT_WRITE_INCR: cmd_reject = incr_bad;
      default:        cmd_reject = 1'b1;
    endcase
  end

  // The step unit moves the candidate one place, wrapping over the axes or the
  // slots; the probe then tests the enable bit or the slot's nonzero flag.
  always_comb begin
    scan_last = scan_axis ? IDX_W'(NUM_AXES - 1) : IDX_W'(NUM_SLOTS - 1);
    if (scan_fwd) begin
      nxt = (cand == scan_last) ? '0 : cand + 1'b1;
    end else begin
      nxt = (cand == '0) ? scan_last : cand - 1'b1;
    end
    axis_hit   = enable_bits[nxt[AXIS_W-1:0]];
    probe_addr = (state == S_CHECK) ? slot_sel : nxt[SLOT_W-1:0];
    hit        = scan_axis ? axis_hit : probe_nonzero;
    slot_ext   = SEXT_W'(slot_sel);
  end

  jais_slot_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .INCR_WIDTH(INCR_WIDTH),
    .SLOT_W    (SLOT_W)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (slot_index[SLOT_W-1:0]),
    .wr_data      (incr_u[INCR_WIDTH-1:0]),
    .rd_addr      (slot_sel),
    .rd_data      (rd_data),
    .probe_addr   (probe_addr),
    .probe_nonzero(probe_nonzero)
  );

  // Sequencer, state and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      increment_limit <= LIMIT_RESET;
      axis_sel        <= '0;
      enable_bits     <= MASK_RESET_EXT[NUM_AXES-1:0];
      slot_sel        <= '0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_valid) begin
        increment_limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            status_r <= cmd_reject ? STATUS_REJECT : STATUS_OK;
            case (action)
              ACT_NEXT_AXIS, ACT_PREV_AXIS: begin
                cand      <= IDX_W'(axis_sel);
                cnt       <= CNT_W'(NUM_AXES);
                scan_fwd  <= (action == ACT_NEXT_AXIS);
                scan_axis <= 1'b1;
                state     <= S_SCAN;
              end
              ACT_SET_MASK: begin
                if (mask_m == '0) begin
                  state <= S_DONE;
                end else if (mask_m != enable_bits) begin
                  enable_bits <= mask_m;
                  if (!mask_m[axis_sel]) begin
                    // Start just before axis 0 so the first probe is axis 0.
                    cand      <= IDX_W'(NUM_AXES - 1);
                    cnt       <= CNT_W'(NUM_AXES);
                    scan_fwd  <= 1'b1;
                    scan_axis <= 1'b1;
                    state     <= S_SCAN;
                  end else begin
                    state <= S_DONE;
                  end
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_WRITE_INCR: begin
                if (incr_bad) begin
                  state <= S_DONE;
                end else begin
                  state <= S_CHECK;
                end
              end
              ACT_ADVANCE: begin
                cand          <= IDX_W'(slot_sel);
                cnt           <= CNT_W'(NUM_SLOTS);
                scan_fwd      <= 1'b1;
                scan_axis     <= 1'b0;
                zero_fallback <= 1'b0;
                state         <= S_SCAN;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_CHECK: begin
          // After a write, an emptied selection searches from slot 1 on.
          if (probe_nonzero) begin
            state <= S_DONE;
          end else begin
            cand          <= '0;
            cnt           <= CNT_W'(NUM_SLOTS);
            scan_fwd      <= 1'b1;
            scan_axis     <= 1'b0;
            zero_fallback <= 1'b1;
            state         <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (scan_axis) begin
              axis_sel <= nxt[AXIS_W-1:0];
            end else begin
              slot_sel <= nxt[SLOT_W-1:0];
            end
            state <= S_DONE;
          end else if (cnt == CNT_W'(1)) begin
            // Nothing found: a write falls back to slot 0, others stay put.
            if (!scan_axis && zero_fallback) begin
              slot_sel <= '0;
            end
            state <= S_DONE;
          end else begin
            cand <= nxt;
            cnt  <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          selected_axis    <= AXIS_FIELD_W'(axis_sel);
          selected_slot    <= slot_ext[SLOT_FIELD_W-1:0];
          active_increment <= rd_data;
          status           <= status_r;
          state            <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : jog_axis_increment_selector_core
`default_nettype wire
